>>> rtl/stereo_peak_rms_level_meter_macros.svh
// Assertion helpers shared by the level meter RTL.
`ifndef STEREO_PEAK_RMS_LEVEL_METER_MACROS_SVH
`define STEREO_PEAK_RMS_LEVEL_METER_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define SLM_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define SLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/slm_pkg.sv
package slm_pkg;

    localparam int SMPL_W = 24;
    localparam int SUM_W  = 58;
    localparam int SQ_W   = 48;
    localparam int DB_W   = 16;
    localparam int CFG_W  = 16;
    localparam int IN_W   = 48;
    localparam int OUT_W  = 112;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam int MAX_BLOCK_DEF = 4096;

    localparam logic [1:0] REG_PEAK_DECAY = 2'd0;
    localparam logic [1:0] REG_RMS_COEF   = 2'd1;
    localparam logic [1:0] REG_DB_FLOOR   = 2'd2;

    localparam logic [CFG_W-1:0] PEAK_DECAY_RST = 16'd64881;
    localparam logic [CFG_W-1:0] RMS_COEF_RST   = 16'd64885;
    localparam logic [CFG_W-1:0] DB_FLOOR_RST   = 16'hC400;

    // 20*log10(2) in Q16
    localparam logic [18:0] DB_K = 19'd394566;

    typedef struct packed {
        logic start;
        logic clear;
    } mac_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_HOLD,
        ST_SMOOTH_A,
        ST_SMOOTH_B,
        ST_DB_GO,
        ST_DB_WAIT,
        ST_EMIT
    } top_state_t;

    typedef enum logic [2:0] {
        DB_IDLE,
        DB_NORM,
        DB_SQR,
        DB_MUL,
        DB_FIN
    } db_state_t;

endpackage

>>> rtl/slm_mac.sv
module slm_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  slm_pkg::mac_ctl_t             ctl,
    input  logic [slm_pkg::SMPL_W-1:0]    sample,
    output logic [slm_pkg::SUM_W-1:0]     sum,
    output logic [slm_pkg::SMPL_W-1:0]    peak,
    output logic                          done
);
    import slm_pkg::*;

    localparam int CW = $clog2(SMPL_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CW-1:0]         cnt_reg;
    logic [SMPL_W-1:0]     mcand_reg;
    logic [2*SMPL_W-1:0]   prod_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SMPL_W-1:0]     max_reg;

    logic [SMPL_W-1:0]     mag;
    logic [SMPL_W:0]       hi_add;
    logic [2*SMPL_W-1:0]   prod_next;
    logic [SUM_W:0]        sum_add;

    // full-scale negative gives 2^(SMPL_W-1), which still fits
    assign mag       = sample[SMPL_W-1] ? (~sample + 1'b1) : sample;
    assign hi_add    = {1'b0, prod_reg[2*SMPL_W-1:SMPL_W]}
                     + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
    assign prod_next = {hi_add, prod_reg[SMPL_W-1:1]};
    assign sum_add   = {1'b0, sum_reg} + (SUM_W+1)'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            mcand_reg <= '0;
            prod_reg  <= '0;
            sum_reg   <= '0;
            max_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.clear)
            begin
                sum_reg <= '0;
                max_reg <= '0;
            end
            if (ctl.start)
            begin
                busy_reg  <= 1'b1;
                cnt_reg   <= '0;
                mcand_reg <= mag;
                prod_reg  <= {{SMPL_W{1'b0}}, mag};
                if (mag > max_reg)
                    max_reg <= mag;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(SMPL_W))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    // saturate on carry out
                    sum_reg  <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                end
                else
                begin
                    prod_reg <= prod_next;
                    cnt_reg  <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign sum  = sum_reg;
    assign peak = max_reg;
    assign done = done_reg;

endmodule

>>> rtl/slm_div.sv
module slm_div #(
    parameter int CNT_W = 13
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [slm_pkg::SUM_W-1:0]     dividend,
    input  logic [CNT_W-1:0]              divisor,
    output logic [slm_pkg::SUM_W-1:0]     quot,
    output logic                          done
);
    import slm_pkg::*;

    localparam int CW = $clog2(SUM_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  q_reg;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    assign trial = {rem_reg, q_reg[SUM_W-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                q_reg    <= dividend;
            end
            else if (busy_reg)
            begin
                // one quotient bit per cycle
                rem_reg <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
                q_reg   <= {q_reg[SUM_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

>>> rtl/slm_sqrt.sv
module slm_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [slm_pkg::SQ_W-1:0]      radicand,
    output logic [slm_pkg::SMPL_W-1:0]    root,
    output logic                          done
);
    import slm_pkg::*;

    localparam int CW    = $clog2(SMPL_W);
    localparam int REM_W = SMPL_W + 2;

    logic               busy_reg;
    logic               done_reg;
    logic [CW-1:0]      cnt_reg;
    logic [SQ_W-1:0]    v_reg;
    logic [SMPL_W-1:0]  root_reg;
    logic [REM_W-1:0]   rem_reg;

    logic [REM_W+1:0]   t;
    logic [REM_W+1:0]   trial;
    logic [REM_W+1:0]   diff;
    logic               ge;

    assign t     = {rem_reg, v_reg[SQ_W-1:SQ_W-2]};
    assign trial = (REM_W+2)'({root_reg, 2'b01});
    assign ge    = t >= trial;
    assign diff  = t - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            v_reg    <= '0;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                v_reg    <= radicand;
                root_reg <= '0;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                // take two radicand bits, decide one root bit
                rem_reg  <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
                root_reg <= {root_reg[SMPL_W-2:0], ge};
                v_reg    <= {v_reg[SQ_W-3:0], 2'b00};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(SMPL_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

>>> rtl/slm_db.sv
module slm_db (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [slm_pkg::SMPL_W-1:0]        x,
    input  logic signed [slm_pkg::DB_W-1:0]   floor_db,
    output logic signed [slm_pkg::DB_W-1:0]   db,
    output logic                              done
);
    import slm_pkg::*;

    localparam int MANT_W    = 31;
    localparam int SQR_STEPS = 16;
    localparam int IT_W      = $clog2(SQR_STEPS);
    localparam int EW        = $clog2(SMPL_W);
    localparam int N_W       = EW + SQR_STEPS;
    localparam int P_W       = N_W + 19;

    db_state_t              st_reg;
    db_state_t              st_next;
    logic [SMPL_W-1:0]      nm_reg;
    logic [EW-1:0]          e_reg;
    logic                   zero_reg;
    logic [MANT_W-1:0]      m_reg;
    logic [SQR_STEPS-1:0]   frac_reg;
    logic [IT_W-1:0]        it_reg;
    logic [P_W-1:0]         prod_reg;

    logic [2*MANT_W-1:0]    sq;
    logic [MANT_W:0]        sq_hi;
    logic [EW-1:0]          ed;
    logic [N_W-1:0]         n;
    logic [P_W:0]           rnd;
    logic signed [17:0]     dbv;
    logic signed [17:0]     fl;
    logic signed [DB_W-1:0] res;

    assign sq    = m_reg * m_reg;
    assign sq_hi = sq[2*MANT_W-1:MANT_W-1];
    assign ed    = EW'(SMPL_W - 1) - e_reg;
    assign n     = {ed, {SQR_STEPS{1'b0}}} - N_W'(frac_reg);
    assign rnd   = {1'b0, prod_reg} + (P_W+1)'(24'h800000);

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            DB_IDLE: if (start) st_next = DB_NORM;
            DB_NORM:
            begin
                if (zero_reg)
                    st_next = DB_FIN;
                else if (nm_reg[SMPL_W-1])
                    st_next = DB_SQR;
            end
            DB_SQR:  if (it_reg == IT_W'(SQR_STEPS - 1)) st_next = DB_MUL;
            DB_MUL:  st_next = DB_FIN;
            DB_FIN:  st_next = DB_IDLE;
            default: st_next = DB_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        fl  = floor_db[DB_W-1] ? 18'(floor_db) : '0;
        dbv = -$signed({1'b0, rnd[P_W:24]});
        if (zero_reg || dbv < fl)
            res = fl[DB_W-1:0];
        else
            res = dbv[DB_W-1:0];
        done = (st_reg == DB_FIN);
        db   = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= DB_IDLE;
            nm_reg   <= '0;
            e_reg    <= '0;
            zero_reg <= 1'b0;
            m_reg    <= '0;
            frac_reg <= '0;
            it_reg   <= '0;
            prod_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            case (st_reg)
                DB_IDLE:
                begin
                    if (start)
                    begin
                        nm_reg   <= x;
                        e_reg    <= EW'(SMPL_W - 1);
                        zero_reg <= (x == '0);
                    end
                end
                DB_NORM:
                begin
                    // normalize one bit per cycle
                    if (zero_reg || nm_reg[SMPL_W-1])
                    begin
                        m_reg    <= {nm_reg, {(MANT_W-SMPL_W){1'b0}}};
                        frac_reg <= '0;
                        it_reg   <= '0;
                    end
                    else
                    begin
                        nm_reg <= {nm_reg[SMPL_W-2:0], 1'b0};
                        e_reg  <= e_reg - 1'b1;
                    end
                end
                DB_SQR:
                begin
                    frac_reg <= {frac_reg[SQR_STEPS-2:0], sq_hi[MANT_W]};
                    m_reg    <= sq_hi[MANT_W] ? sq_hi[MANT_W:1] : sq_hi[MANT_W-1:0];
                    it_reg   <= it_reg + 1'b1;
                end
                DB_MUL:  prod_reg <= n * DB_K;
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/stereo_peak_rms_level_meter.sv
// Stereo peak / RMS level meter.
//
// Input stream: one word per stereo sample pair, s_tdata holds the left and
// right samples (signed Q1.23), s_tlast marks the last pair of a block. A
// block also ends on the pair that brings the count to MAX_BLOCK.
// s_tready stays low from the acceptance of a pair until it is done: the
// two channels square their magnitude in parallel with a bit-serial
// shift-add multiplier, one multiplier bit per cycle.
// At block end the block emits two words, left then right (tuser is the
// channel, tlast marks the right one). For each channel a bit-serial divider
// forms mean square, a two-bit-per-step root unit gives RMS, a short
// multiply sequence updates peak hold and smoothed RMS, and one shared log
// unit converts four levels to dB, with a shorter path for a zero level.
// No input is taken from the last pair of a block until the right word is
// loaded.
// A result waits in the output register while the receiver stalls; sample
// pairs are still accepted then, and end-of-block work stalls only when the
// next result has to be loaded.
// Reset clears accumulators, peak hold and smoothed RMS, and loads the
// register defaults. Registers (APB, byte address 4*i): peak_decay,
// rms_smooth_coef, db_floor; write them only while the meter is idle.
`include "stereo_peak_rms_level_meter_macros.svh"

module stereo_peak_rms_level_meter #(
    parameter int MAX_BLOCK = slm_pkg::MAX_BLOCK_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [slm_pkg::IN_W-1:0]      s_tdata,   // left_sample, right_sample
    input  logic                          s_tlast,   // block_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // peak_db, peak_hold_db, rms_db, rms_smooth_db, peak_hold_level,
    // rms_smooth_level
    output logic [slm_pkg::OUT_W-1:0]     m_tdata,
    output logic                          m_tuser,   // channel
    output logic                          m_tlast,   // run_last
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slm_pkg::APB_AW-1:0]    paddr,
    input  logic [slm_pkg::APB_DW-1:0]    pwdata,
    output logic [slm_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import slm_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);

    // config registers
    logic [CFG_W-1:0]        decay_reg;
    logic [CFG_W-1:0]        coef_reg;
    logic [CFG_W-1:0]        floor_reg;

    // sequencer
    top_state_t              state_reg;
    top_state_t              state_next;
    logic                    ch_reg;
    logic [1:0]              db_sel_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    end_reg;

    // per-channel ballistics and results
    logic [SMPL_W-1:0]       hold_reg   [2];
    logic [SMPL_W-1:0]       smooth_reg [2];
    logic [SMPL_W-1:0]       rms_reg;
    logic [40:0]             prod_a_reg;
    logic [39:0]             prod_b_reg;
    logic [DB_W-1:0]         db_reg [4];

    // output register
    logic                    m_tvalid_reg;
    logic [OUT_W-1:0]        m_tdata_reg;
    logic                    m_tuser_reg;
    logic                    m_tlast_reg;

    // unit wiring
    mac_ctl_t                ctl [2];
    logic [SUM_W-1:0]        lane_sum  [2];
    logic [SMPL_W-1:0]       lane_peak [2];
    logic                    mac_done  [2];
    logic                    div_start;
    logic                    div_done;
    logic [SUM_W-1:0]        quot;
    logic                    sqrt_start;
    logic                    sqrt_done;
    logic [SMPL_W-1:0]       root;
    logic                    db_start;
    logic                    db_done;
    logic [DB_W-1:0]         db_out;
    logic [SMPL_W-1:0]       db_x;

    logic                    accept;
    logic                    out_free;
    logic                    emit_go;
    logic [CNT_W-1:0]        count_inc;
    logic                    blk_end;
    logic                    cfg_wr;
    logic [39:0]             hold_mul;
    logic [40:0]             rms_mul;
    logic [39:0]             smooth_mul;
    logic [41:0]             smooth_sum;
    logic [16:0]             coef_inv;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign count_inc = count_reg + 1'b1;
    // a block also closes when the pair count reaches its limit
    assign blk_end   = end_reg || (count_inc == CNT_W'(MAX_BLOCK));
    assign coef_inv  = 17'h10000 - {1'b0, coef_reg};

    assign hold_mul   = hold_reg[ch_reg] * decay_reg;
    assign rms_mul    = rms_reg * coef_inv;
    assign smooth_mul = smooth_reg[ch_reg] * coef_reg;
    assign smooth_sum = {1'b0, prod_a_reg} + {2'b00, prod_b_reg};

    // register read back
    always_comb
    begin
        case (paddr[3:2])
            REG_PEAK_DECAY: prdata = {16'h0, decay_reg};
            REG_RMS_COEF:   prdata = {16'h0, coef_reg};
            REG_DB_FLOOR:   prdata = {16'h0, floor_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= PEAK_DECAY_RST;
            coef_reg  <= RMS_COEF_RST;
            floor_reg <= DB_FLOOR_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_PEAK_DECAY: decay_reg <= pwdata[CFG_W-1:0];
                REG_RMS_COEF:   coef_reg  <= pwdata[CFG_W-1:0];
                REG_DB_FLOOR:   floor_reg <= pwdata[CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    // accumulator lanes, left and right
    slm_mac u_mac_l (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl[0]),
        .sample (s_tdata[SMPL_W-1:0]),
        .sum    (lane_sum[0]),
        .peak   (lane_peak[0]),
        .done   (mac_done[0])
    );

    slm_mac u_mac_r (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl[1]),
        .sample (s_tdata[2*SMPL_W-1:SMPL_W]),
        .sum    (lane_sum[1]),
        .peak   (lane_peak[1]),
        .done   (mac_done[1])
    );

    slm_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (lane_sum[ch_reg]),
        .divisor  (count_reg),
        .quot     (quot),
        .done     (div_done)
    );

    // the mean square never exceeds 2^46, so the low bits carry it all
    slm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (quot[SQ_W-1:0]),
        .root     (root),
        .done     (sqrt_done)
    );

    slm_db u_db (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (db_start),
        .x        (db_x),
        .floor_db (floor_reg),
        .db       (db_out),
        .done     (db_done)
    );

    // level fed to the log unit: peak, hold, rms, smoothed rms
    always_comb
    begin
        case (db_sel_reg)
            2'd0:    db_x = lane_peak[ch_reg];
            2'd1:    db_x = hold_reg[ch_reg];
            2'd2:    db_x = rms_reg;
            default: db_x = smooth_reg[ch_reg];
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_ACC;
            ST_ACC:
            begin
                if (mac_done[0])
                    state_next = blk_end ? ST_DIV_GO : ST_IDLE;
            end
            ST_DIV_GO:    state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (div_done) state_next = ST_SQRT_GO;
            ST_SQRT_GO:   state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT: if (sqrt_done) state_next = ST_HOLD;
            ST_HOLD:      state_next = ST_SMOOTH_A;
            ST_SMOOTH_A:  state_next = ST_SMOOTH_B;
            ST_SMOOTH_B:  state_next = ST_DB_GO;
            ST_DB_GO:     state_next = ST_DB_WAIT;
            ST_DB_WAIT:
            begin
                if (db_done)
                    state_next = (db_sel_reg == 2'd3) ? ST_EMIT : ST_DB_GO;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ch_reg ? ST_IDLE : ST_DIV_GO;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready      = (state_reg == ST_IDLE);
        accept        = s_tvalid && s_tready;
        div_start     = (state_reg == ST_DIV_GO);
        sqrt_start    = (state_reg == ST_SQRT_GO);
        db_start      = (state_reg == ST_DB_GO);
        emit_go       = (state_reg == ST_EMIT) && out_free;
        ctl[0].start  = accept;
        ctl[1].start  = accept;
        // drop the block totals of a channel once its word is loaded
        ctl[0].clear  = emit_go && !ch_reg;
        ctl[1].clear  = emit_go && ch_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= 1'b0;
            db_sel_reg    <= '0;
            count_reg     <= '0;
            end_reg       <= 1'b0;
            hold_reg[0]   <= '0;
            hold_reg[1]   <= '0;
            smooth_reg[0] <= '0;
            smooth_reg[1] <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                end_reg <= s_tlast;
            if (state_reg == ST_ACC && mac_done[0])
                count_reg <= count_inc;
            if (state_reg == ST_HOLD)
            begin
                // jump up to the peak, else decay
                if (lane_peak[ch_reg] > hold_reg[ch_reg])
                    hold_reg[ch_reg] <= lane_peak[ch_reg];
                else
                    hold_reg[ch_reg] <= hold_mul[39:16];
            end
            if (state_reg == ST_SMOOTH_B)
            begin
                if (rms_reg > smooth_reg[ch_reg])
                    smooth_reg[ch_reg] <= rms_reg;
                else
                    smooth_reg[ch_reg] <= smooth_sum[39:16];
            end
            if (state_reg == ST_DB_WAIT && db_done)
                db_sel_reg <= db_sel_reg + 1'b1;
            if (emit_go)
            begin
                ch_reg <= !ch_reg;
                if (ch_reg)
                    count_reg <= '0;
            end
            // output register: load on emit, drop once taken
            if (emit_go)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SQRT_WAIT && sqrt_done)
            rms_reg <= root;
        if (state_reg == ST_HOLD)
            prod_a_reg <= rms_mul;
        if (state_reg == ST_SMOOTH_A)
            prod_b_reg <= smooth_mul;
        if (state_reg == ST_DB_WAIT && db_done)
            db_reg[db_sel_reg] <= db_out;
        if (emit_go)
        begin
            m_tdata_reg <= {smooth_reg[ch_reg], hold_reg[ch_reg],
                            db_reg[3], db_reg[2], db_reg[1], db_reg[0]};
            m_tuser_reg <= ch_reg;
            m_tlast_reg <= ch_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `SLM_ASSERT(a_last_on_right, m_tvalid, m_tlast == m_tuser, "tlast must mark the right channel word")
    `SLM_ASSERT(a_level_range, m_tvalid, (m_tdata[111:88] <= 24'h800000) && (m_tdata[87:64] <= 24'h800000), "linear level above full scale")
    `SLM_ASSERT(a_db_nonpos, m_tvalid, m_tdata[15] || (m_tdata[15:0] == 16'h0), "peak dB above zero")
    `SLM_ASSERT_NEXT(a_count_clear, emit_go && ch_reg, count_reg == '0, "pair count not cleared after block")

endmodule
